// ----- rtl/mlps_pkg.sv -----
// Shared constants and types for the midpoint line pixel stepper.
// No dependencies; used by midpoint_line_pixel_stepper_top.
`timescale 1ns / 1ps
`default_nettype none

package mlps_pkg;

    localparam int COORD_BITS  = 12;
    localparam int DELTA_BITS  = COORD_BITS + 1;   // doubled delta, 2*(2^n-1)
    localparam int ERR_BITS    = COORD_BITS + 3;   // signed doubled error term
    localparam int WIDTH_BITS  = 13;
    localparam int OFFSET_BITS = 24;

    localparam logic [WIDTH_BITS-1:0] FRAME_WIDTH_RESET = WIDTH_BITS'(1280);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } command_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic                   last;
    } pixel_t;

endpackage

`default_nettype wire

// ----- rtl/midpoint_line_pixel_stepper_top.sv -----
// Midpoint line pixel stepper, top level.
// Depends on mlps_pkg (constants, command codes, pixel result struct).
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - Command channel (cmd_valid / cmd_stall): a transaction with command = load
//   latches start_x/start_y/end_x/end_y and produces no pixel. A transaction
//   with command = step emits one pixel of the loaded line, or nothing when no
//   line is active (empty line, decreasing direction, or line finished).
// - Pixel channel (pix_valid / pix_stall): one transaction per emitted pixel
//   with pixel_offset = y*frame_width + x (mod 2^24), pixel_x, pixel_y, last.
// - Config channel (cfg_valid / cfg_ready): writes frame_width; cfg_ready is
//   always high. Write only while the block is idle.
// Timing
// - One command per clock sustained while cmd_stall is low. A step's pixel is
//   registered in the output register, or in the skid register when the
//   receiver stalls. The step is a sign test and adds on the error term and
//   running offset; the load's start offset uses a single 12x13 multiply.
// - When the receiver stalls, the pixel holds in the output register and one
//   more pixel is caught in a skid register; cmd_stall then rises, registered,
//   so no combinational path runs from pix_stall to cmd_stall.
// Reset: rst_n clears the line (no line loaded), the valid flags of both output
// registers and sets frame_width to 1280.

module midpoint_line_pixel_stepper_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // command channel
    input  wire logic                                 cmd_valid,
    output logic                                      cmd_stall,
    input  wire logic                                 command,
    input  wire logic [mlps_pkg::COORD_BITS-1:0]      start_x,
    input  wire logic [mlps_pkg::COORD_BITS-1:0]      start_y,
    input  wire logic [mlps_pkg::COORD_BITS-1:0]      end_x,
    input  wire logic [mlps_pkg::COORD_BITS-1:0]      end_y,
    // pixel channel
    output logic                                      pix_valid,
    input  wire logic                                 pix_stall,
    output logic [mlps_pkg::OFFSET_BITS-1:0]          pixel_offset,
    output logic [mlps_pkg::COORD_BITS-1:0]           pixel_x,
    output logic [mlps_pkg::COORD_BITS-1:0]           pixel_y,
    output logic                                      last,
    // config channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mlps_pkg::WIDTH_BITS-1:0]      frame_width
);

    localparam int CB = mlps_pkg::COORD_BITS;
    localparam int DB = mlps_pkg::DELTA_BITS;
    localparam int EB = mlps_pkg::ERR_BITS;
    localparam int WB = mlps_pkg::WIDTH_BITS;
    localparam int OB = mlps_pkg::OFFSET_BITS;

    // ---------------- state ----------------
    logic [WB-1:0]        frame_width_reg;
    logic [CB-1:0]        cur_x_reg, cur_x_next;
    logic [CB-1:0]        cur_y_reg, cur_y_next;
    logic [CB-1:0]        stop_coord_reg, stop_coord_next;
    logic [DB-1:0]        twice_dx_reg, twice_dx_next;
    logic [DB-1:0]        twice_dy_reg, twice_dy_next;
    logic signed [EB-1:0] error_term_reg, error_term_next;
    logic                 steep_mode_reg, steep_mode_next;
    logic                 line_active_reg, line_active_next;
    logic [OB-1:0]        run_offset_reg, run_offset_next;

    // output register plus skid
    mlps_pkg::pixel_t     out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    mlps_pkg::pixel_t     skid_reg, skid_next;
    logic                 skid_valid_reg, skid_valid_next;

    logic                 cmd_accept;
    logic                 emit;
    mlps_pkg::pixel_t     emit_pix;

    // load-side arithmetic
    logic [CB:0]          dx_ld, dy_ld;
    logic                 decreasing;
    logic [CB+WB-1:0]     start_prod;

    // step-side arithmetic
    logic [CB-1:0]        sx, sy;
    logic [OB-1:0]        soff;
    logic signed [EB-1:0] serr;
    logic [OB-1:0]        fw_ext;
    logic signed [EB-1:0] tdx_ext, tdy_ext;
    logic                 step_last;

    assign cfg_ready  = 1'b1;
    assign cmd_stall  = skid_valid_reg;
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign fw_ext  = OB'(frame_width_reg);
    assign tdx_ext = EB'(twice_dx_reg);
    assign tdy_ext = EB'(twice_dy_reg);

    assign dx_ld      = {1'b0, end_x} - {1'b0, start_x};
    assign dy_ld      = {1'b0, end_y} - {1'b0, start_y};
    assign decreasing = (end_x < start_x) || (end_y < start_y);
    assign start_prod = start_y * frame_width_reg;

    // line state update
    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        stop_coord_next  = stop_coord_reg;
        twice_dx_next    = twice_dx_reg;
        twice_dy_next    = twice_dy_reg;
        error_term_next  = error_term_reg;
        steep_mode_next  = steep_mode_reg;
        line_active_next = line_active_reg;
        run_offset_next  = run_offset_reg;
        emit             = 1'b0;
        sx               = cur_x_reg;
        sy               = cur_y_reg;
        soff             = run_offset_reg;
        serr             = error_term_reg;
        step_last        = 1'b0;

        // minor-axis move before the pixel is emitted
        if (!steep_mode_reg) begin
            if (!error_term_reg[EB-1]) begin
                sy   = cur_y_reg + 1'b1;
                soff = run_offset_reg + fw_ext;
                serr = error_term_reg - tdx_ext;
            end
            step_last = ((cur_x_reg + 1'b1) == stop_coord_reg);
        end else begin
            if (error_term_reg[EB-1]) begin
                sx   = cur_x_reg + 1'b1;
                soff = run_offset_reg + 1'b1;
                serr = error_term_reg + tdy_ext;
            end
            step_last = ((cur_y_reg + 1'b1) == stop_coord_reg);
        end

        emit_pix.offset = soff;
        emit_pix.x      = sx;
        emit_pix.y      = sy;
        emit_pix.last   = step_last;

        if (cmd_accept) begin
            unique case (mlps_pkg::command_t'(command))
                mlps_pkg::CMD_LOAD:
                begin
                    cur_x_next      = start_x;
                    cur_y_next      = start_y;
                    run_offset_next = start_prod[OB-1:0] + OB'(start_x);
                    if (decreasing) begin
                        twice_dx_next    = '0;
                        twice_dy_next    = '0;
                        error_term_next  = '0;
                        steep_mode_next  = 1'b0;
                        stop_coord_next  = start_x;
                        line_active_next = 1'b0;
                    end else begin
                        twice_dx_next = {dx_ld[CB-1:0], 1'b0};
                        twice_dy_next = {dy_ld[CB-1:0], 1'b0};
                        if (dy_ld <= dx_ld) begin
                            steep_mode_next  = 1'b0;
                            stop_coord_next  = end_x;
                            error_term_next  = -$signed(EB'(dx_ld));
                            line_active_next = (dx_ld != '0);
                        end else begin
                            steep_mode_next  = 1'b1;
                            stop_coord_next  = end_y;
                            error_term_next  = $signed(EB'(dy_ld));
                            line_active_next = 1'b1;
                        end
                    end
                end
                mlps_pkg::CMD_STEP:
                begin
                    if (line_active_reg) begin
                        emit            = 1'b1;
                        cur_x_next      = sx;
                        cur_y_next      = sy;
                        run_offset_next = soff;
                        error_term_next = serr;
                        if (step_last) begin
                            line_active_next = 1'b0;
                        end else if (!steep_mode_reg) begin
                            cur_x_next      = sx + 1'b1;
                            run_offset_next = soff + 1'b1;
                            error_term_next = serr + tdy_ext;
                        end else begin
                            cur_y_next      = sy + 1'b1;
                            run_offset_next = soff + fw_ext;
                            error_term_next = serr - tdx_ext;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register and skid
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || !pix_stall) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = emit_pix;
                out_valid_next = emit;
            end
        end else if (emit) begin
            skid_next       = emit_pix;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_width_reg <= mlps_pkg::FRAME_WIDTH_RESET;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            stop_coord_reg  <= '0;
            twice_dx_reg    <= '0;
            twice_dy_reg    <= '0;
            error_term_reg  <= '0;
            steep_mode_reg  <= 1'b0;
            line_active_reg <= 1'b0;
            run_offset_reg  <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                frame_width_reg <= frame_width;
            end
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            stop_coord_reg  <= stop_coord_next;
            twice_dx_reg    <= twice_dx_next;
            twice_dy_reg    <= twice_dy_next;
            error_term_reg  <= error_term_next;
            steep_mode_reg  <= steep_mode_next;
            line_active_reg <= line_active_next;
            run_offset_reg  <= run_offset_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign pix_valid    = out_valid_reg;
    assign pixel_offset = out_reg.offset;
    assign pixel_x      = out_reg.x;
    assign pixel_y      = out_reg.y;
    assign last         = out_reg.last;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a pixel while the output register is empty");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && step_last) |=> !line_active_reg)
        else $error("line still active after its last pixel");

    a_decreasing_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && command == mlps_pkg::CMD_LOAD && decreasing)
            |=> !line_active_reg)
        else $error("decreasing line loaded as active");

    a_shallow_before_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (line_active_reg && !steep_mode_reg) |-> (cur_x_reg != stop_coord_reg))
        else $error("active shallow line sits on its stop column");

    a_stall_keeps_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pix_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled pixel lost or changed");

endmodule

`default_nettype wire

// ----- tb/sv/midpoint_line_pixel_stepper_top_tb.sv -----
// Self-checking testbench for midpoint_line_pixel_stepper_top.
// Depends on mlps_pkg and the RTL top; a directed table runs first, then random line traffic
// under random stalls, checked against an in-bench line tracer or typed table values.
`timescale 1ns / 1ps

module midpoint_line_pixel_stepper_top_tb;

    import mlps_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;      // long receiver hold-off, fills the skid path
    localparam int SETTLE      = 4;       // output register plus skid slot, with margin
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    // How a directed row is checked: by the tracer, by a value typed into the table, or not at all.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_PIXEL
    } check_t;

    typedef struct packed {
        command_t              op;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        check_t                chk;
        pixel_t                pix;
    } stim_row_t;

    // ------------------------------------------------------------------
    // DUT ports; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cmd_valid   = 1'b0;
    logic                   command     = CMD_LOAD;
    logic [COORD_BITS-1:0]  start_x     = '0;
    logic [COORD_BITS-1:0]  start_y     = '0;
    logic [COORD_BITS-1:0]  end_x       = '0;
    logic [COORD_BITS-1:0]  end_y       = '0;
    logic                   pix_stall   = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic [WIDTH_BITS-1:0]  frame_width = FRAME_WIDTH_RESET;
    logic                   cmd_stall;
    logic                   pix_valid;
    logic [OFFSET_BITS-1:0] pixel_offset;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic                   last;
    logic                   cfg_ready;

    midpoint_line_pixel_stepper_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pixel_offset (pixel_offset),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .frame_width  (frame_width)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Line tracer state: mirrors the block's registers after reset
    // ------------------------------------------------------------------
    logic [WIDTH_BITS-1:0]  line_width  = FRAME_WIDTH_RESET;
    logic [COORD_BITS-1:0]  line_x      = '0;
    logic [COORD_BITS-1:0]  line_y      = '0;
    logic [COORD_BITS-1:0]  line_stop   = '0;
    logic [OFFSET_BITS-1:0] line_offset = '0;
    int                     line_2dx    = 0;
    int                     line_2dy    = 0;
    int                     line_err    = 0;   // doubled midpoint error, signed
    bit                     line_steep  = 1'b0;
    bit                     line_active = 1'b0;

    pixel_t pending_pixels[$];   // expected pixels, oldest first
    int     fault_count  = 0;
    int     items_done   = 0;
    int     cycle_count  = 0;
    int     hold_left    = 0;
    bit     holdoff_req  = 1'b0;
    bit     holdoff_done = 1'b0;
    bit     quiet        = 1'b0;   // no idling on either side while set
    pixel_t seen_pix;
    pixel_t due_pix;

    // Directed rows. Typed values only where they are obvious: no pixel after reset,
    // after a finished line, for empty or decreasing lines, and one-pixel lines.
    stim_row_t directed_rows [25] = '{
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_NONE,  '0},
        '{CMD_LOAD, 12'd5,    12'd2,    12'd6,    12'd2,    CHK_NONE,  '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_PIXEL,
          '{24'd2565, 12'd5, 12'd2, 1'b1}},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_NONE,  '0},
        '{CMD_LOAD, 12'd0,    12'd0,    12'd1,    12'd0,    CHK_NONE,  '0},
        '{CMD_STEP, 12'd4095, 12'd4095, 12'd4095, 12'd4095, CHK_PIXEL,
          '{24'd0, 12'd0, 12'd0, 1'b1}},
        // equal endpoints at the far corner: empty line
        '{CMD_LOAD, 12'd4095, 12'd4095, 12'd4095, 12'd4095, CHK_NONE,  '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_NONE,  '0},
        // decreasing x, then decreasing y: both empty
        '{CMD_LOAD, 12'd10,   12'd0,    12'd5,    12'd3,    CHK_NONE,  '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_NONE,  '0},
        '{CMD_LOAD, 12'd0,    12'd10,   12'd3,    12'd5,    CHK_NONE,  '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_NONE,  '0},
        // shallow line ending at the top coordinate
        '{CMD_LOAD, 12'd4093, 12'd4094, 12'd4095, 12'd4095, CHK_NONE,  '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_MODEL, '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_MODEL, '0},
        // long steep line, cut short by the next load
        '{CMD_LOAD, 12'd0,    12'd0,    12'd1,    12'd4095, CHK_NONE,  '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_MODEL, '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_MODEL, '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_MODEL, '0},
        '{CMD_LOAD, 12'd100,  12'd200,  12'd103,  12'd203,  CHK_NONE,  '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_MODEL, '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_MODEL, '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_MODEL, '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_MODEL, '0},
        '{CMD_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    CHK_NONE,  '0}
    };

    // ------------------------------------------------------------------
    // Line tracer: applies one command, returns 1 with the pixel if one is drawn
    // ------------------------------------------------------------------
    function automatic bit trace_line(input command_t op,
                                      input logic [COORD_BITS-1:0] sx, sy, ex, ey,
                                      output pixel_t px);
        int dx;
        int dy;
        px = '0;
        if (op == CMD_LOAD) begin
            line_active = 1'b0;
            line_x      = sx;
            line_y      = sy;
            line_offset = OFFSET_BITS'(32'(sy) * 32'(line_width) + 32'(sx));
            if (ex < sx || ey < sy) begin
                line_2dx   = 0;
                line_2dy   = 0;
                line_err   = 0;
                line_steep = 1'b0;
                line_stop  = sx;
                return 1'b0;
            end
            dx = int'(ex) - int'(sx);
            dy = int'(ey) - int'(sy);
            line_2dx = 2 * dx;
            line_2dy = 2 * dy;
            if (dy <= dx) begin
                line_steep  = 1'b0;
                line_stop   = ex;
                line_err    = -dx;
                line_active = (dx > 0);
            end
            else begin
                line_steep  = 1'b1;
                line_stop   = ey;
                line_err    = dy;
                line_active = 1'b1;
            end
            return 1'b0;
        end

        if (!line_active)
            return 1'b0;

        // minor-axis step first, then the pixel, then the major-axis step
        if (!line_steep) begin
            if (line_err >= 0) begin
                line_y      = line_y + 1'b1;
                line_offset = line_offset + OFFSET_BITS'(line_width);
                line_err    = line_err - line_2dx;
            end
            px.last = (COORD_BITS'(line_x + 1'b1) == line_stop);
        end
        else begin
            if (line_err < 0) begin
                line_x      = line_x + 1'b1;
                line_offset = line_offset + 1'b1;
                line_err    = line_err + line_2dy;
            end
            px.last = (COORD_BITS'(line_y + 1'b1) == line_stop);
        end
        px.offset = line_offset;
        px.x      = line_x;
        px.y      = line_y;

        if (px.last)
            line_active = 1'b0;
        else if (!line_steep) begin
            line_x      = line_x + 1'b1;
            line_offset = line_offset + 1'b1;
            line_err    = line_err + line_2dy;
        end
        else begin
            line_y      = line_y + 1'b1;
            line_offset = line_offset + OFFSET_BITS'(line_width);
            line_err    = line_err - line_2dx;
        end
        return 1'b1;
    endfunction

    function automatic logic [COORD_BITS-1:0] any_coord();
        return COORD_BITS'($urandom_range(COORD_MAX));
    endfunction

    function automatic void log_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("pixel check failed at cycle %0d: %s", cycle_count, what);
    endfunction

    // ------------------------------------------------------------------
    // Command channel driver. Idle gaps are decided before the offer, so
    // cmd_valid never follows cmd_stall; the payload holds until accepted.
    // Returns in the acceptance time step with the transaction applied to the tracer.
    // ------------------------------------------------------------------
    task automatic offer_command(input command_t op,
                                 input logic [COORD_BITS-1:0] sx, sy, ex, ey,
                                 input check_t chk, input pixel_t typed);
        pixel_t px;
        bit     drawn;
        while (!quiet && $urandom_range(99) < 26) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command   <= op;
        start_x   <= sx;
        start_y   <= sy;
        end_x     <= ex;
        end_y     <= ey;
        do
            @(posedge clk);
        while (cmd_stall);
        drawn = trace_line(op, sx, sy, ex, ey, px);
        if (chk == CHK_MODEL && drawn)
            pending_pixels.push_back(px);
        else if (chk == CHK_PIXEL)
            pending_pixels.push_back(typed);
        if (op == CMD_LOAD || drawn)
            items_done++;
    endtask

    // Drop valid, wait for every expected pixel, then let the pipe go quiet.
    task automatic settle_block();
        cmd_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Width write; only called with the block settled. A line in progress
    // carries on with the new width for its later rows.
    task automatic set_frame_width(input logic [WIDTH_BITS-1:0] w);
        cfg_valid   <= 1'b1;
        frame_width <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        line_width = w;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed load-then-step sequences, some noise
    // (stray steps, arbitrary loads, zero-length lines).
    // ------------------------------------------------------------------
    task automatic run_phase(input int quota);
        int                    stop_at;
        int                    pick;
        int                    dx;
        int                    dy;
        int                    ex_i;
        int                    ey_i;
        int                    len;
        int                    steps;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        stop_at = items_done + quota;
        while (items_done < stop_at) begin
            pick = $urandom_range(99);
            sx   = any_coord();
            sy   = any_coord();
            if (pick < 80) begin
                // mostly short lines; now and then a huge one, only partly walked
                if (pick < 4) begin
                    dx = $urandom_range(COORD_MAX);
                    dy = $urandom_range(COORD_MAX);
                end
                else begin
                    dx = $urandom_range(16);
                    dy = $urandom_range(16);
                end
                ex_i = int'(sx) + dx;
                ey_i = int'(sy) + dy;
                if (ex_i > COORD_MAX)
                    ex_i = COORD_MAX;
                if (ey_i > COORD_MAX)
                    ey_i = COORD_MAX;
                len = ex_i - int'(sx);
                if (ey_i - int'(sy) > len)
                    len = ey_i - int'(sy);
                if (pick < 4)
                    steps = $urandom_range(40);
                else if ($urandom_range(9) == 0)
                    steps = $urandom_range(len);        // abandoned mid-line
                else
                    steps = len + $urandom_range(2);    // run past the end too
                offer_command(CMD_LOAD, sx, sy, COORD_BITS'(ex_i), COORD_BITS'(ey_i),
                              CHK_MODEL, '0);
                repeat (steps)
                    offer_command(CMD_STEP, any_coord(), any_coord(), any_coord(),
                                  any_coord(), CHK_MODEL, '0);
            end
            else if (pick < 88)
                offer_command(CMD_STEP, sx, sy, any_coord(), any_coord(), CHK_MODEL, '0);
            else if (pick < 96)
                offer_command(CMD_LOAD, sx, sy, any_coord(), any_coord(), CHK_MODEL, '0);
            else
                offer_command(CMD_LOAD, sx, sy, sx, sy, CHK_MODEL, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Pixel receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pix_stall <= 1'b1;
        end
        else if (holdoff_req && !holdoff_done) begin
            hold_left    <= HOLD_CYCLES;
            holdoff_done <= 1'b1;
            pix_stall    <= 1'b1;
        end
        else
            pix_stall <= !quiet && ($urandom_range(99) < 26);
    end

    // ------------------------------------------------------------------
    // Pixel checker: each transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && pix_valid && !pix_stall) begin
            seen_pix = '{pixel_offset, pixel_x, pixel_y, last};
            if (pending_pixels.size() == 0)
                log_fault($sformatf("unexpected pixel off=%0d x=%0d y=%0d last=%0d",
                                    seen_pix.offset, seen_pix.x, seen_pix.y,
                                    seen_pix.last));
            else begin
                due_pix = pending_pixels.pop_front();
                if (seen_pix.offset !== due_pix.offset || seen_pix.x !== due_pix.x ||
                    seen_pix.y !== due_pix.y || seen_pix.last !== due_pix.last)
                    log_fault($sformatf(
                        "expected off=%0d x=%0d y=%0d last=%0d, got off=%0d x=%0d y=%0d last=%0d",
                        due_pix.offset, due_pix.x, due_pix.y, due_pix.last,
                        seen_pix.offset, seen_pix.x, seen_pix.y, seen_pix.last));
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog
    always @(posedge clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset width
        foreach (directed_rows[i])
            offer_command(directed_rows[i].op, directed_rows[i].sx, directed_rows[i].sy,
                          directed_rows[i].ex, directed_rows[i].ey,
                          directed_rows[i].chk, directed_rows[i].pix);
        settle_block();

        // width of one; a long line walked while the receiver holds off
        set_frame_width(WIDTH_BITS'(1));
        holdoff_req <= 1'b1;
        offer_command(CMD_LOAD, 12'd10, 12'd20, 12'd300, 12'd90, CHK_MODEL, '0);
        repeat (80)
            offer_command(CMD_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
                          CHK_MODEL, '0);
        run_phase(100);
        settle_block();

        set_frame_width(WIDTH_BITS'(4096));
        run_phase(110);
        settle_block();

        // all-ones width wraps the offset; this phase runs with no idling
        set_frame_width(WIDTH_BITS'(8191));
        quiet <= 1'b1;
        run_phase(110);
        quiet <= 1'b0;
        settle_block();

        set_frame_width(WIDTH_BITS'(0));
        run_phase(110);
        settle_block();

        set_frame_width(WIDTH_BITS'($urandom_range(1, 4096)));
        run_phase(110);
        settle_block();

        if (fault_count == 0 && pending_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
